/* hw/rtl/fm_phase_discriminator_assert.svh */
// Assertion macros for the FM phase discriminator.
// Expects clk_i and rst_ni in the including module's scope.
`ifndef FM_PHASE_DISCRIMINATOR_ASSERT_SVH
`define FM_PHASE_DISCRIMINATOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define FMPD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define FMPD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/fmpd_pkg.sv */
// Shared types, constants and the arctangent table of the FM phase discriminator.
// No dependencies.
package fmpd_pkg;

  // Phase resolution of the binary angle and CORDIC step count.
  localparam int PhaseBits   = 16;
  localparam int CordicIters = 16;
  localparam int IterW       = $clog2(CordicIters);

  // CORDIC datapath width: 17-bit magnitude grown by the CORDIC gain.
  localparam int CordicW     = 20;

  // Audio and filter formats.
  localparam int SampleW     = 16;
  localparam int AudioW      = 32;
  localparam int CoeffW      = 16;
  localparam int FullScaleSh = 15;  // 32767 = 2^15 - 1

  // Register indexes on the configuration port.
  localparam logic [1:0] RegRate   = 2'd0;
  localparam logic [1:0] RegCoeff  = 2'd1;
  localparam logic [1:0] RegEnable = 2'd2;
  localparam logic [1:0] RegStereo = 2'd3;

  // Register reset values.
  localparam logic [15:0] RateReset  = 16'd3413;
  localparam logic [15:0] CoeffReset = 16'd23895;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StCordic,
    StMul,
    StScale,
    StFilt,
    StFin
  } state_e;

  // Status of the CORDIC unit.
  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // atan(2^-i) as a 32-bit binary angle (full turn 2^32).
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/fmpd_cordic.sv */
// Iterative vectoring CORDIC: one shift-add micro-rotation per cycle.
// Depends on fmpd_pkg.
module fmpd_cordic
  import fmpd_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [SampleW-1:0]   i_i,
  input  logic signed [SampleW-1:0]   q_i,
  output cordic_stat_t                stat_o,
  output logic        [PhaseBits-1:0] phase_o
);

  localparam logic [31:0] PhaseRound = 32'(1) << (31 - PhaseBits);
  localparam logic [31:0] HalfTurn   = 32'h8000_0000;

  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic                      zero_q, zero_d;
  logic [IterW-1:0]          cnt_q, cnt_d;
  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d;
  logic [31:0]               acc_q, acc_d;

  logic signed [CordicW-1:0] xi, yi, xs, ys;
  logic [31:0]               atan_v, acc_r;

  // Start vector, turned by a half turn when I is negative
  assign xi = CordicW'(i_i);
  assign yi = CordicW'(q_i);

  // Shared shifter and add/sub for one micro-rotation
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign atan_v = atan_turn(5'(cnt_q));

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (start_i) begin
      run_d  = 1'b1;
      zero_d = (i_i == '0) && (q_i == '0);
      cnt_d  = '0;
      if (i_i[SampleW-1]) begin
        x_d   = -xi;
        y_d   = -yi;
        acc_d = HalfTurn;
      end else begin
        x_d   = xi;
        y_d   = yi;
        acc_d = '0;
      end
    end else if (run_q) begin
      if (!y_q[CordicW-1]) begin
        x_d   = x_q + ys;
        y_d   = y_q - xs;
        acc_d = acc_q + atan_v;
      end else begin
        x_d   = x_q - ys;
        y_d   = y_q + xs;
        acc_d = acc_q - atan_v;
      end
      cnt_d = cnt_q + IterW'(1);
      if (cnt_q == IterW'(CordicIters - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
  end

  // Round the accumulator half up to the phase width; a zero vector has phase 0
  assign acc_r   = acc_q + PhaseRound;
  assign phase_o = zero_q ? '0 : acc_r[31 -: PhaseBits];

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;

endmodule

/* hw/rtl/fm_phase_discriminator.sv */
// FM polar discriminator: CORDIC phase, phase step, gain and optional one-pole de-emphasis.
// Each request runs 16 CORDIC steps, then the StMul, StScale, StFilt and StFin states.
// The single shared CORDIC add/sub unit takes one request at a time: input is ready only
// in StIdle, and StFin waits while the output is stalled. Stereo mode gives two results per request.
// Reset: registers return to their defaults, previous phase and filter state clear.
// Depends on fmpd_pkg, fmpd_cordic and fm_phase_discriminator_assert.svh.
`include "fm_phase_discriminator_assert.svh"

module fm_phase_discriminator
  import fmpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] i_sample, [31:16] q_sample
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] audio_pcm
  output logic        m_axis_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int P1W = PhaseBits + CoeffW + 1;
  localparam int P2W = PhaseBits + AudioW;
  localparam int EW  = AudioW + 1;
  localparam int PW  = EW + CoeffW + 1;
  localparam logic signed [P2W-1:0] ScaleRound = P2W'(1) <<< (PhaseBits - 1);
  localparam logic signed [PW-1:0]  FiltRound  = PW'(32768);
  localparam logic signed [AudioW:0] SampRound = (AudioW+1)'(128);
  localparam logic signed [AudioW+2:0] AudMax = (AudioW+3)'(33'sh0_7FFF_FFFF);
  localparam logic signed [AudioW+2:0] AudMin = -(AudioW+3)'(33'sh0_8000_0000);
  localparam logic signed [AudioW-8:0] SmpMax = (AudioW-7)'(32767);
  localparam logic signed [AudioW-8:0] SmpMin = -(AudioW-7)'(32768);

  // Configuration registers
  logic [15:0] rate_q, coeff_q;
  logic        enable_q, stereo_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RateReset;
      coeff_q  <= CoeffReset;
      enable_q <= 1'b1;
      stereo_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegRate:   rate_q   <= pwdata[15:0];
        RegCoeff:  coeff_q  <= pwdata[15:0];
        RegEnable: enable_q <= pwdata[0];
        RegStereo: stereo_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegRate:   prdata = {16'd0, rate_q};
      RegCoeff:  prdata = {16'd0, coeff_q};
      RegEnable: prdata = {31'd0, enable_q};
      RegStereo: prdata = {31'd0, stereo_q};
      default:   prdata = '0;
    endcase
  end

  // Sequencer and CORDIC unit
  state_e              state_q, state_d;
  cordic_stat_t        cstat;
  logic [PhaseBits-1:0] phase;
  logic                in_acc, out_acc, fin_load;
  logic [1:0]          out_cnt_q, out_cnt_d;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  fmpd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .i_i     (s_axis_tdata[15:0]),
    .q_i     (s_axis_tdata[31:16]),
    .stat_o  (cstat),
    .phase_o (phase)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_acc) state_d = StCordic;
      StCordic: if (cstat.done) state_d = StMul;
      StMul:    state_d = StScale;
      StScale:  state_d = StFilt;
      StFilt:   state_d = StFin;
      StFin:    if (out_cnt_q == 2'd0) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Output load: the result leaves once the output register is empty
  always_comb begin
    fin_load = 1'b0;
    unique case (state_q)
      StFin:   fin_load = (out_cnt_q == 2'd0);
      default: fin_load = 1'b0;
    endcase
  end

  // Datapath registers
  logic [PhaseBits-1:0]        prev_q, dstep_q;
  logic signed [P1W-1:0]       p1_q;
  logic signed [AudioW-1:0]    x_q, fo_q, y;
  logic signed [PW-1:0]        prod_q;
  logic [SampleW-1:0]          samp_q, samp;
  logic signed [P2W-1:0]       p2;
  logic signed [EW-1:0]        err;
  logic signed [PW-1:0]        prod_r;
  logic signed [AudioW+2:0]    ysum;
  logic signed [AudioW:0]      yr;
  logic signed [AudioW-8:0]    ys;

  // Scale step: d * rate * (2^15 - 1), rounded half up, shifted by the phase width.
  // Magnitude stays below 2^31 over the whole input range.
  assign p2  = ((P2W'(p1_q)) <<< FullScaleSh) - P2W'(p1_q) + ScaleRound;
  assign err = EW'(x_q) - EW'(fo_q);

  // Filter update with rounding and saturation, bypassed when enable is clear
  assign prod_r = (prod_q + FiltRound) >>> 16;
  assign ysum   = (AudioW+3)'(fo_q) + (AudioW+3)'(prod_r);
  always_comb begin
    if (!enable_q) begin
      y = x_q;
    end else if (ysum > AudMax) begin
      y = AudioW'(AudMax);
    end else if (ysum < AudMin) begin
      y = AudioW'(AudMin);
    end else begin
      y = AudioW'(ysum);
    end
  end

  // Round to whole samples and saturate to 16 bits
  assign yr = ((AudioW+1)'(y) + SampRound) >>> 8;
  always_comb begin
    ys = yr[AudioW-8:0];
    if (ys > SmpMax) begin
      samp = 16'h7FFF;
    end else if (ys < SmpMin) begin
      samp = 16'h8000;
    end else begin
      samp = ys[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      fo_q   <= '0;
    end else begin
      if (state_q == StCordic && cstat.done) prev_q <= phase;
      if (fin_load) fo_q <= y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StCordic && cstat.done) dstep_q <= phase - prev_q;
    if (state_q == StMul)   p1_q   <= $signed(dstep_q) * $signed({1'b0, rate_q});
    if (state_q == StScale) x_q    <= p2[PhaseBits +: AudioW];
    if (state_q == StFilt)  prod_q <= $signed({1'b0, coeff_q}) * err;
    if (fin_load)           samp_q <= samp;
  end

  // Output register: one or two copies of the sample
  always_comb begin
    out_cnt_d = out_cnt_q;
    if (fin_load) begin
      out_cnt_d = stereo_q ? 2'd2 : 2'd1;
    end else if (out_acc) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_cnt_q <= 2'd0;
    end else begin
      state_q   <= state_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tlast  = (out_cnt_q == 2'd1);
  assign m_axis_tdata  = samp_q;

  // Assertions
  `FMPD_ASSERT(a_ready_idle_unit, s_axis_tready |-> !cstat.busy,
               "input ready while CORDIC busy")
  `FMPD_ASSERT(a_accept_starts, in_acc |=> (state_q == StCordic) && cstat.busy,
               "accepted request did not start CORDIC")
  `FMPD_ASSERT(a_done_in_cordic, cstat.done |-> (state_q == StCordic),
               "CORDIC done outside its state")
  `FMPD_ASSERT(a_last_drains, out_acc && m_axis_tlast |=> !m_axis_tvalid,
               "output still valid after last result")

endmodule
